// ===== rtl/tcon_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcon_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // field widths
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int LIN_W  = 12;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // control characters
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;

   // tab stops every four columns
   localparam logic [COL_W:0] TAB_STEP = (COL_W+1)'(4);
   localparam logic [COL_W:0] TAB_MASK = ~(COL_W+1)'(3);

   // register file
   localparam int                 CSR_ADDR_W  = 3;
   localparam int                 CSR_DATA_W  = 32;
   localparam logic [ATTR_W-1:0]  ATTR_RESET  = 8'h07;
   localparam logic               CSR_IDX_ATTR = 1'b0;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/text_console_cell_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted beat's result is registered and appears in the cycle after acceptance; an in-range
// cell read goes through the registered memory read and ST_READ before its result is registered
// throughput: one beat per cycle for writes, cursor moves and rejected reads while the result
// channel is not stalled; a cell read holds the input off in ST_READ; clear and scroll sweep the
// cell memory through its single write port and hold the input off until the last write is done
// reset: cursor homed, attribute 7; a clearing pass blanks all cells before accepting a beat
module text_console_cell_writer
   import tcon_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,   // char_code, target_row, target_col
   input  wire logic [1:0]            req_tuser,   // command
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,   // cursor_row_out, cursor_col_out,
                                                   // cursor_linear, cell_value
   output logic [0:0]                 rsp_tuser,   // rejected
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // cell index of a row and column
   function automatic logic [LIN_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_index = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
   endfunction

   // request fields
   cmd_type             req_cmd;
   logic [CHAR_W-1:0]   req_char;
   logic [ROW_W-1:0]    req_row;
   logic [COL_W-1:0]    req_col;

   assign req_cmd  = cmd_type'(req_tuser);
   assign req_char = req_tdata[7:0];
   assign req_row  = req_tdata[12:8];
   assign req_col  = req_tdata[19:13];

   // state
   state_type           state_ff, state_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ATTR_W-1:0]   attr_ff;
   logic [ATTR_W-1:0]   blank_attr_ff, blank_attr_in;
   logic                scroll_ff, scroll_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                cp_valid_ff, cp_valid_in;
   logic                cp_blank_ff, cp_blank_in;
   logic [ADDR_W-1:0]   cp_addr_ff, cp_addr_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [LIN_W-1:0]    rsp_lin_ff, rsp_lin_in;
   logic [CELL_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic                rsp_rej_ff, rsp_rej_in;

   // cell memory
   logic [CELL_W-1:0]   mem [CELL_COUNT];
   logic [CELL_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CELL_W-1:0]   wr_data;

   logic                accept;
   logic                in_range;
   logic [LIN_W-1:0]    cur_lin;
   logic [LIN_W-1:0]    tgt_lin;
   logic [COL_W:0]      col_p1;
   logic [COL_W:0]      tab_col;
   logic                at_last_row;
   logic                sweep_last;

   assign accept      = req_tvalid && req_tready;
   assign in_range    = ({1'b0, req_row} < (ROW_W+1)'(ROWS)) &&
                        ({1'b0, req_col} < (COL_W+1)'(COLUMNS));
   assign cur_lin     = cell_index(row_ff, col_ff);
   assign tgt_lin     = cell_index(req_row, req_col);
   assign col_p1      = {1'b0, col_ff} + (COL_W+1)'(1);
   assign tab_col     = ({1'b0, col_ff} + TAB_STEP) & TAB_MASK;
   assign at_last_row = (row_ff == ROW_W'(ROWS - 1));
   assign sweep_last  = (sweep_ff == ADDR_W'(CELL_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_READ && in_range) begin
                  state_in = ST_READ;
               end else if (req_cmd == CMD_CLEAR || scroll_in) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake, memory port and sweep control
   always_comb begin
      req_tready    = 1'b0;
      rd_addr       = ADDR_W'(tgt_lin);
      cp_valid_in   = 1'b0;
      cp_blank_in   = 1'b1;
      cp_addr_in    = sweep_ff;
      sweep_in      = sweep_ff;
      blank_attr_in = blank_attr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !cp_valid_ff && (!rsp_valid_ff || rsp_tready);
            sweep_in   = '0;
            if (accept && (req_cmd == CMD_CLEAR || scroll_in)) begin
               blank_attr_in = attr_ff;
            end
         end
         ST_READ: begin
            req_tready = 1'b0;
         end
         ST_SWEEP: begin
            rd_addr     = sweep_ff + ADDR_W'(COLUMNS);
            cp_valid_in = 1'b1;
            cp_blank_in = !scroll_ff || (sweep_ff >= ADDR_W'(COPY_COUNT));
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // cursor update and result payload
   always_comb begin
      logic adv_row;
      logic [CELL_W-1:0] new_cell;
      adv_row      = 1'b0;
      new_cell     = {attr_ff, req_char};
      row_in       = row_ff;
      col_in       = col_ff;
      scroll_in    = scroll_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(cur_lin);
      wr_data      = new_cell;
      rsp_rej_in   = rsp_rej_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // pending sweep write, copied cell or blank
      if (cp_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = cp_addr_ff;
         wr_data = cp_blank_ff ? {blank_attr_ff, CHAR_BLANK} : rd_data_ff;
      end

      if (accept) begin
         rsp_rej_in  = 1'b0;
         rsp_cell_in = '0;
         case (req_cmd)
            CMD_WRITE: begin
               case (req_char)
                  CHAR_NEWLINE: begin
                     adv_row = 1'b1;
                  end
                  CHAR_RETURN: begin
                     col_in = '0;
                  end
                  CHAR_TAB: begin
                     if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                        adv_row = 1'b1;
                     end else begin
                        col_in = tab_col[COL_W-1:0];
                     end
                  end
                  default: begin
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(cur_lin);
                     wr_data = new_cell;
                     if (col_p1 >= (COL_W+1)'(COLUMNS)) begin
                        adv_row = 1'b1;
                     end else begin
                        col_in = col_p1[COL_W-1:0];
                     end
                  end
               endcase
            end
            CMD_CLEAR: begin
               row_in = '0;
               col_in = '0;
            end
            CMD_SET: begin
               if (in_range) begin
                  row_in = req_row;
                  col_in = req_col;
               end else begin
                  rsp_rej_in = 1'b1;
               end
            end
            default: begin
               rsp_rej_in = !in_range;
            end
         endcase

         // next row, scrolling when already on the bottom row
         scroll_in = 1'b0;
         if (adv_row) begin
            col_in = '0;
            if (at_last_row) begin
               scroll_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end

         // result now, or once the cell read returns
         rsp_valid_in = !(req_cmd == CMD_READ && in_range);
      end

      if (state_ff == ST_READ) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in  = rd_data_ff;
      end

      rsp_row_in = row_in;
      rsp_col_in = col_in;
      rsp_lin_in = cell_index(row_in, col_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_ff        <= '0;
         col_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         blank_attr_ff <= ATTR_RESET;
         scroll_ff     <= 1'b0;
         sweep_ff      <= '0;
         cp_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         blank_attr_ff <= blank_attr_in;
         scroll_ff     <= scroll_in;
         sweep_ff      <= sweep_in;
         cp_valid_ff   <= cp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1] == CSR_IDX_ATTR) begin
            attr_ff <= csr_pwdata[ATTR_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cp_blank_ff <= cp_blank_in;
      cp_addr_ff  <= cp_addr_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_lin_ff  <= rsp_lin_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   // cell memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cell_ff, rsp_lin_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_rej_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_ATTR) ?
                       CSR_DATA_W'(attr_ff) : '0;

   // checks
   a_no_accept_during_drain : assert property (@(posedge clock) disable iff (reset)
      cp_valid_ff |-> !accept)
      else $error("beat accepted while a sweep write is pending");

   a_cursor_in_range : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, row_ff} < (ROW_W+1)'(ROWS)) && ({1'b0, col_ff} < (COL_W+1)'(COLUMNS)))
      else $error("cursor outside the screen");

   a_read_returns : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff)
      else $error("cell read produced no result");

   a_sweep_blocks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req_tready)
      else $error("request ready during a sweep");

endmodule

`default_nettype wire
